// ===== rtl/dmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmm_pkg;

  // Largest matrix dimension held in the element stores
  localparam int MAX_DIM = 8;
  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam logic [3:0] DIM_LIMIT = 4'(MAX_DIM);

  // Element and result widths
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int SUM_W = 36;

  // APB register file
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_RESULT_ROWS = 2'd0;
  localparam logic [1:0] REG_INNER_LENGTH = 2'd1;
  localparam logic [1:0] REG_RESULT_COLS = 2'd2;
  localparam logic [1:0] REG_B_TRANSPOSED = 2'd3;

  // Input item kinds
  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] element_value;
  } item_t;

  typedef struct packed {
    logic [2:0]             c_row;
    logic [2:0]             c_col;
    logic signed [SUM_W-1:0] c_value;
    logic                   last;
  } result_t;

  // Tags that follow one inner-product step down the datapath
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_c;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } step_tag_t;

  // Last index of a dimension register: zero counts as one, large values saturate
  function automatic logic [DIM_W-1:0] dim_last(input logic [3:0] d);
    logic [DIM_W-1:0] r;
    if (d == 4'd0) begin
      r = '0;
    end else if (d > DIM_LIMIT) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(d - 4'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/dense_matrix_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Load items (kind A or B) leave busy_o low, so one may follow every cycle.
// A compute item holds busy_o while its steps run and drain, one inner-product step per cycle through
// the element memories' single read port; C(i,j) strobes from the result register after its last step.
// Results cannot be stalled: each shows on valid_o for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears control, config (8, 8, 8, 0) and the sum register;
// element memories are undefined until written.
module dense_matrix_multiply (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire dmm_pkg::item_t                item_i,
  // result channel
  output logic                               valid_o,
  output dmm_pkg::result_t                   result_o,
  // APB configuration port
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [dmm_pkg::PADDR_W-1:0]   paddr_i,
  input  wire logic [31:0]                   pwdata_i,
  output logic [31:0]                        prdata_o,
  output logic                               pready_o
);

  import dmm_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [3:0] rows_q, inner_q, cols_q;
  logic       trans_q;

  logic [DIM_W-1:0] nr_last_q, nk_last_q, nc_last_q;
  logic [DIM_W-1:0] i_q, j_q, k_q;
  logic [DIM_W-1:0] i_d, j_d, k_d;

  logic accept, do_compute, in_range;
  logic we_a, we_b;
  logic [ADDR_W-1:0] load_addr, a_addr, b_addr, a_run_addr, b_run_addr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  logic      s1_q, s2_q;
  step_tag_t tag0, s1_tag_q, s2_tag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d;

  logic    valid_q;
  result_t result_q;

  // APB register file
  logic       cfg_we;
  logic [1:0] reg_idx;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i & pready_o;
  assign reg_idx  = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 4'd8;
      inner_q <= 4'd8;
      cols_q  <= 4'd8;
      trans_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_RESULT_ROWS:  rows_q  <= pwdata_i[3:0];
        REG_INNER_LENGTH: inner_q <= pwdata_i[3:0];
        REG_RESULT_COLS:  cols_q  <= pwdata_i[3:0];
        REG_B_TRANSPOSED: trans_q <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RESULT_ROWS:  prdata_o = {28'd0, rows_q};
      REG_INNER_LENGTH: prdata_o = {28'd0, inner_q};
      REG_RESULT_COLS:  prdata_o = {28'd0, cols_q};
      REG_B_TRANSPOSED: prdata_o = {31'd0, trans_q};
      default:          prdata_o = '0;
    endcase
  end

  // Item decode
  assign busy_o     = (state_q == StRun) | s1_q | s2_q;
  assign accept     = start_i & ~busy_o;
  assign do_compute = accept & (item_i.kind == KIND_COMPUTE);
  assign in_range   = ({1'b0, item_i.row_index} < DIM_LIMIT) &
                      ({1'b0, item_i.col_index} < DIM_LIMIT);
  assign we_a = accept & in_range & (item_i.kind == KIND_LOAD_A);
  assign we_b = accept & in_range & (item_i.kind == KIND_LOAD_B);

  assign load_addr = ADDR_W'(ADDR_W'(item_i.row_index) * ADDR_W'(MAX_DIM))
                   + ADDR_W'(item_i.col_index);

  // Step addresses: A(i,k), B(k,j) or B'(j,k)
  assign a_run_addr = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_DIM)) + ADDR_W'(k_q);
  assign b_run_addr = trans_q
      ? ADDR_W'(ADDR_W'(j_q) * ADDR_W'(MAX_DIM)) + ADDR_W'(k_q)
      : ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM)) + ADDR_W'(j_q);

  assign a_addr = (state_q == StRun) ? a_run_addr : load_addr;
  assign b_addr = (state_q == StRun) ? b_run_addr : load_addr;

  dmm_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .addr_i  (a_addr),
    .wdata_i (item_i.element_value),
    .rdata_o (a_rdata)
  );

  dmm_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .addr_i  (b_addr),
    .wdata_i (item_i.element_value),
    .rdata_o (b_rdata)
  );

  // Step sequencer: k innermost, then j, then i
  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    unique case (state_q)
      StIdle: begin
        if (do_compute) begin
          state_d = StRun;
          i_d = '0;
          j_d = '0;
          k_d = '0;
        end
      end
      StRun: begin
        if (k_q == nk_last_q) begin
          k_d = '0;
          if (j_q == nc_last_q) begin
            j_d = '0;
            if (i_q == nr_last_q) begin
              state_d = StIdle;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      nr_last_q <= '0;
      nk_last_q <= '0;
      nc_last_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (do_compute) begin
        nr_last_q <= dim_last(rows_q);
        nk_last_q <= dim_last(inner_q);
        nc_last_q <= dim_last(cols_q);
      end
    end
  end

  assign tag0.first  = (k_q == '0);
  assign tag0.last_k = (k_q == nk_last_q);
  assign tag0.last_c = (i_q == nr_last_q) & (j_q == nc_last_q);
  assign tag0.row    = i_q;
  assign tag0.col    = j_q;

  // Datapath: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= 1'b0;
      s2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      s1_q <= (state_q == StRun);
      s2_q <= s1_q;
      if (s2_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= tag0;
    s2_tag_q <= s1_tag_q;
    prod_q   <= $signed(a_rdata) * $signed(b_rdata);
  end

  always_comb begin
    acc_d = (s2_tag_q.first ? '0 : acc_q)
          + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s2_q & s2_tag_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q & s2_tag_q.last_k) begin
      result_q.c_row   <= 3'(s2_tag_q.row);
      result_q.c_col   <= 3'(s2_tag_q.col);
      result_q.c_value <= acc_d;
      result_q.last    <= s2_tag_q.last_c;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_strobe_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(s2_q))
    else $error("result strobe without a finished step");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_compute |=> (state_q == StRun))
    else $error("compute item did not start the sequencer");

  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.last) |=> !valid_o)
    else $error("result strobe follows the last item of a run");

  a_no_load_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> !(we_a || we_b))
    else $error("element write during a compute run");
`endif

endmodule

`default_nettype wire

// ===== test/dmm_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, result and APB channels of the matrix multiplier,
// keeps its own copy of the element stores and shape registers, predicts the
// C elements of every compute item and compares them in order.
module dmm_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command channel
  input  wire logic                        start_i,
  input  wire logic                        busy_i,
  input  wire dmm_pkg::item_t              item_i,
  // result channel
  input  wire logic                        valid_i,
  input  wire dmm_pkg::result_t            result_i,
  // APB configuration port
  input  wire logic                        psel_i,
  input  wire logic                        penable_i,
  input  wire logic                        pwrite_i,
  input  wire logic [dmm_pkg::PADDR_W-1:0] paddr_i,
  input  wire logic [31:0]                 pwdata_i,
  input  wire logic [31:0]                 prdata_i,
  input  wire logic                        pready_i,
  // status towards the stimulus side
  output int                               fail_count_o,
  output int                               pending_o
);

  import dmm_pkg::*;

  // Shadow shape registers
  logic [3:0] rows_q;
  logic [3:0] inner_q;
  logic [3:0] cols_q;
  logic       b_trans_q;

  // Shadow element stores, row * MAX_DIM + col
  logic signed [ELEM_W-1:0] a_elems [STORE_DEPTH];
  logic signed [ELEM_W-1:0] b_elems [STORE_DEPTH];

  // C elements still to come, oldest first
  result_t c_elems_due [$];

  result_t     due;
  logic [31:0] reg_value;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  // Zero counts as one, anything above MAX_DIM saturates
  function automatic int clamp_dim(input logic [3:0] d);
    if (d == 4'd0) begin
      return 1;
    end
    if (d > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(d);
  endfunction

  // Inner products of the current stores, queued in row-major order
  function automatic void queue_c_matrix();
    int      nr;
    int      nk;
    int      nc;
    int      b_idx;
    longint  acc;
    longint  a_val;
    longint  b_val;
    result_t elem;
    nr = clamp_dim(rows_q);
    nk = clamp_dim(inner_q);
    nc = clamp_dim(cols_q);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          b_idx = b_trans_q ? (j * MAX_DIM + k) : (k * MAX_DIM + j);
          a_val = a_elems[i * MAX_DIM + k];
          b_val = b_elems[b_idx];
          acc += a_val * b_val;
        end
        elem.c_row = 3'(i);
        elem.c_col = 3'(j);
        elem.c_value = acc[SUM_W-1:0];
        elem.last = (i == nr - 1) && (j == nc - 1);
        c_elems_due.push_back(elem);
      end
    end
  endfunction

  // One line per mismatch, and count it
  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("dmm_checker @%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q = 4'd8;
      inner_q = 4'd8;
      cols_q = 4'd8;
      b_trans_q = 1'b0;
      c_elems_due.delete();
      pending_o = 0;
    end else begin
      // results first: none can belong to an item taken at this edge
      if (valid_i) begin
        if (c_elems_due.size() == 0) begin
          report_mismatch($sformatf("unexpected C(%0d,%0d) value %0d",
                                    result_i.c_row, result_i.c_col, result_i.c_value));
        end else begin
          due = c_elems_due.pop_front();
          if (result_i.c_row !== due.c_row || result_i.c_col !== due.c_col ||
              result_i.c_value !== due.c_value || result_i.last !== due.last) begin
            report_mismatch($sformatf(
              "C(%0d,%0d) got at (%0d,%0d) value %0d last %0b, want value %0d last %0b",
              due.c_row, due.c_col, result_i.c_row, result_i.c_col,
              result_i.c_value, result_i.last, due.c_value, due.last));
          end
        end
      end

      // accepted command items
      if (start_i && !busy_i) begin
        case (item_i.kind)
          KIND_LOAD_A: a_elems[{item_i.row_index, item_i.col_index}] = item_i.element_value;
          KIND_LOAD_B: b_elems[{item_i.row_index, item_i.col_index}] = item_i.element_value;
          KIND_COMPUTE: queue_c_matrix();
          default: ;
        endcase
      end

      // register writes and read-back
      if (psel_i && penable_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_RESULT_ROWS:  reg_value = {28'd0, rows_q};
          REG_INNER_LENGTH: reg_value = {28'd0, inner_q};
          REG_RESULT_COLS:  reg_value = {28'd0, cols_q};
          default:          reg_value = {31'd0, b_trans_q};
        endcase
        if (pwrite_i) begin
          case (paddr_i[PADDR_W-1:2])
            REG_RESULT_ROWS:  rows_q = pwdata_i[3:0];
            REG_INNER_LENGTH: inner_q = pwdata_i[3:0];
            REG_RESULT_COLS:  cols_q = pwdata_i[3:0];
            REG_B_TRANSPOSED: b_trans_q = pwdata_i[0];
            default: ;
          endcase
        end else if (prdata_i !== reg_value) begin
          report_mismatch($sformatf("register at 0x%0h read 0x%0h, want 0x%0h",
                                    paddr_i, prdata_i, reg_value));
        end
      end

      pending_o = c_elems_due.size();
    end
  end

endmodule

// ===== test/tb_dense_matrix_multiply.sv =====
`timescale 1ns / 1ps

module tb_dense_matrix_multiply;
  import dmm_pkg::*;

  localparam int ITEM_TARGET = 200;
  localparam int CALM_TAIL = 50;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_W = $bits(item_t);
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  item_t              item;
  logic               valid;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending_elems;

  // shape as last written, and which store entries hold data
  logic [3:0] rows_w;
  logic [3:0] inner_w;
  logic [3:0] cols_w;
  logic       b_trans_w;
  bit         a_loaded [STORE_DEPTH];
  bit         b_loaded [STORE_DEPTH];

  int items_sent;
  bit idle_allowed;
  bit phase_idle;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  dense_matrix_multiply u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .start_i   (start),
    .busy_o    (busy),
    .item_i    (item),
    .valid_o   (valid),
    .result_o  (result),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  dmm_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item),
    .valid_i      (valid),
    .result_i     (result),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending_elems)
  );

  function automatic int eff_dim(input logic [3:0] d);
    if (d == 4'd0) begin
      return 1;
    end
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // Mostly random, with the Q8.8 extremes now and then
  function automatic logic [15:0] random_element();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return 16'h7FFF;
    end else if (pick == 1) begin
      return 16'h8000;
    end else if (pick == 2) begin
      return 16'hFFFF;
    end else if (pick == 3) begin
      return 16'h0000;
    end
    return 16'($urandom);
  endfunction

  // Mostly small shapes, sometimes zero, full or saturating
  function automatic logic [3:0] pick_dim();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return 4'd0;
    end else if (pick == 1) begin
      return 4'd8;
    end else if (pick == 2) begin
      return 4'($urandom_range(9, 15));
    end
    return 4'($urandom_range(1, 4));
  endfunction

  // Present one item and hold it until taken; start stays high on return
  task automatic send_item(input item_t it);
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      item <= ITEM_W'($urandom);
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_element(input logic [1:0] kind, input logic [2:0] row,
                              input logic [2:0] col, input logic [15:0] value);
    item_t it;
    it.kind = kind;
    it.row_index = row;
    it.col_index = col;
    it.element_value = value;
    if (kind == KIND_LOAD_A) begin
      a_loaded[{row, col}] = 1'b1;
    end else if (kind == KIND_LOAD_B) begin
      b_loaded[{row, col}] = 1'b1;
    end
    send_item(it);
  endtask

  // Load whatever the current shape reads that has never been written
  task automatic fill_operands();
    int nr;
    int nk;
    int nc;
    nr = eff_dim(rows_w);
    nk = eff_dim(inner_w);
    nc = eff_dim(cols_w);
    for (int i = 0; i < nr; i++) begin
      for (int k = 0; k < nk; k++) begin
        if (!a_loaded[i * MAX_DIM + k]) begin
          load_element(KIND_LOAD_A, 3'(i), 3'(k), random_element());
        end
      end
    end
    for (int j = 0; j < nc; j++) begin
      for (int k = 0; k < nk; k++) begin
        if (b_trans_w && !b_loaded[j * MAX_DIM + k]) begin
          load_element(KIND_LOAD_B, 3'(j), 3'(k), random_element());
        end else if (!b_trans_w && !b_loaded[k * MAX_DIM + j]) begin
          load_element(KIND_LOAD_B, 3'(k), 3'(j), random_element());
        end
      end
    end
  endtask

  // Compute item with junk in the fields it ignores
  task automatic run_compute();
    item_t it;
    fill_operands();
    it = ITEM_W'($urandom);
    it.kind = KIND_COMPUTE;
    send_item(it);
  endtask

  // Load item aimed mostly inside the current shape
  task automatic load_random_element();
    logic [1:0] kind;
    int         row;
    int         col;
    int         nr;
    int         nk;
    int         nc;
    nr = eff_dim(rows_w);
    nk = eff_dim(inner_w);
    nc = eff_dim(cols_w);
    kind = ($urandom_range(0, 1) == 1) ? KIND_LOAD_B : KIND_LOAD_A;
    row = $urandom_range(0, MAX_DIM - 1);
    col = $urandom_range(0, MAX_DIM - 1);
    if ($urandom_range(0, 3) != 0) begin
      if (kind == KIND_LOAD_A) begin
        row = $urandom_range(0, nr - 1);
        col = $urandom_range(0, nk - 1);
      end else if (b_trans_w) begin
        row = $urandom_range(0, nc - 1);
        col = $urandom_range(0, nk - 1);
      end else begin
        row = $urandom_range(0, nk - 1);
        col = $urandom_range(0, nc - 1);
      end
    end
    load_element(kind, 3'(row), 3'(col), random_element());
  endtask

  // Drop start, then wait for the block to drain fully
  task automatic wait_idle();
    start <= 1'b0;
    item <= ITEM_W'($urandom);
    @(negedge clk);
    while (pending_elems != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB setup and access cycles; starts and ends at a falling edge
  task automatic apb_access(input logic write, input logic [1:0] idx,
                            input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_shape(input logic [3:0] r, input logic [3:0] k,
                           input logic [3:0] c, input logic bt);
    wait_idle();
    rows_w = r;
    inner_w = k;
    cols_w = c;
    b_trans_w = bt;
    // unused upper bits carry noise
    apb_access(1'b1, REG_RESULT_ROWS, {28'($urandom), r});
    apb_access(1'b1, REG_INNER_LENGTH, {28'($urandom), k});
    apb_access(1'b1, REG_RESULT_COLS, {28'($urandom), c});
    apb_access(1'b1, REG_B_TRANSPOSED, {31'($urandom), bt});
    apb_access(1'b0, REG_RESULT_ROWS, 32'd0);
    apb_access(1'b0, REG_INNER_LENGTH, 32'd0);
    apb_access(1'b0, REG_RESULT_COLS, 32'd0);
    apb_access(1'b0, REG_B_TRANSPOSED, 32'd0);
  endtask

  initial begin
    item_t junk;
    rst_n = 1'b0;
    start = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    idle_allowed = 1'b1;
    rows_w = 4'd8;
    inner_w = 4'd8;
    cols_w = 4'd8;
    b_trans_w = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single element: largest positive, mixed sign and largest products
    set_shape(4'd1, 4'd1, 4'd1, 1'b0);
    load_element(KIND_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
    load_element(KIND_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
    run_compute();
    load_element(KIND_LOAD_A, 3'd0, 3'd0, 16'h8000);
    run_compute();
    load_element(KIND_LOAD_B, 3'd0, 3'd0, 16'h8000);
    run_compute();
    // unused kind must leave the stores alone
    junk = ITEM_W'($urandom);
    junk.kind = KIND_UNUSED;
    junk.row_index = 3'd0;
    junk.col_index = 3'd0;
    send_item(junk);
    run_compute();

    // zero rows and cols count as one, oversized inner length saturates;
    // full-length sum of most negative squares gives the largest magnitude
    set_shape(4'd0, 4'd15, 4'd0, 1'b1);
    for (int k = 0; k < MAX_DIM; k++) begin
      load_element(KIND_LOAD_A, 3'd0, 3'(k), 16'h8000);
      load_element(KIND_LOAD_B, 3'd0, 3'(k), 16'h8000);
    end
    run_compute();

    // outer product, 8 x 1 x 8
    set_shape(4'd15, 4'd0, 4'd15, 1'b0);
    run_compute();

    // random phases, each under its own shape
    while (items_sent < ITEM_TARGET) begin
      set_shape(pick_dim(), pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
      phase_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(8, 30)) begin
        idle_allowed = phase_idle && (items_sent < ITEM_TARGET - CALM_TAIL);
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            run_compute();
          end
          3: begin
            junk = ITEM_W'($urandom);
            junk.kind = KIND_UNUSED;
            send_item(junk);
          end
          default: begin
            load_random_element();
          end
        endcase
      end
      idle_allowed = phase_idle && (items_sent < ITEM_TARGET - CALM_TAIL);
      run_compute();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
